### hw/rtl/fdse_pkg.sv
// ----------------------------------------------------------------------------
// fdse_pkg
// Shared types, character codes and glyph shapes of the segment display
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fdse_pkg;

  localparam int unsigned NumPositionsDefault = 4;
  localparam int unsigned OutFields           = 4;
  localparam int unsigned SegW                = 11;
  localparam int unsigned ShapeW              = 10;
  localparam int unsigned NumW                = 16;
  localparam int unsigned InDataW             = 40;
  localparam int unsigned OutDataW            = 48;

  typedef enum logic {
    CmdShowNumber = 1'b0,
    CmdSetDigit   = 1'b1
  } cmd_e;

  localparam logic [7:0] DigitMax   = 8'd9;
  localparam logic [7:0] CharSpace  = 8'd32;
  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharNine   = 8'd57;
  localparam logic [7:0] CharUpperC = 8'd67;
  localparam logic [7:0] CharDegree = 8'd176;

  localparam logic [ShapeW-1:0] ShapeBlank  = 10'h000;
  localparam logic [ShapeW-1:0] ShapeDegree = 10'h0E3;
  localparam logic [ShapeW-1:0] ShapeUpperC = 10'h039;

  typedef struct packed {
    logic              known;
    logic [ShapeW-1:0] shape;
  } glyph_t;

  typedef struct packed {
    cmd_e            cmd;
    logic [NumW-1:0] number;
    logic [7:0]      places;
    logic [1:0]      position;
    logic [7:0]      code;
  } fdse_req_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] places;
    logic [1:0] position;
    logic [7:0] code;
  } fdse_ctrl_t;

  function automatic logic [ShapeW-1:0] digit_shape(logic [3:0] digit);
    logic [ShapeW-1:0] shape;
    case (digit)
      4'd0:    shape = 10'h03F;
      4'd1:    shape = 10'h006;
      4'd2:    shape = 10'h0DB;
      4'd3:    shape = 10'h0CF;
      4'd4:    shape = 10'h0E6;
      4'd5:    shape = 10'h0ED;
      4'd6:    shape = 10'h0FD;
      4'd7:    shape = 10'h007;
      4'd8:    shape = 10'h0FF;
      4'd9:    shape = 10'h0EF;
      default: shape = ShapeBlank;
    endcase
    return shape;
  endfunction

  function automatic glyph_t glyph_of(logic [7:0] code);
    glyph_t     g;
    logic [7:0] ascii_digit;
    ascii_digit = code - CharZero;
    g.known     = 1'b1;
    if (code <= DigitMax) begin
      g.shape = digit_shape(code[3:0]);
    end else if (code >= CharZero && code <= CharNine) begin
      g.shape = digit_shape(ascii_digit[3:0]);
    end else if (code == CharSpace) begin
      g.shape = ShapeBlank;
    end else if (code == CharDegree) begin
      g.shape = ShapeDegree;
    end else if (code == CharUpperC) begin
      g.shape = ShapeUpperC;
    end else begin
      g.known = 1'b0;
      g.shape = ShapeBlank;
    end
    return g;
  endfunction

  // floor(n / 10**k) by reciprocal multiply, exact over the whole 16-bit range
  function automatic logic [NumW-1:0] div_pow10(logic [NumW-1:0] n, int unsigned k);
    logic [32:0] prod;
    logic [32:0] shifted;
    prod    = '0;
    shifted = '0;
    case (k)
      0: begin
        shifted = {17'd0, n};
      end
      1: begin
        prod    = {17'd0, n} * 33'd52429;
        shifted = prod >> 19;
      end
      2: begin
        prod    = {17'd0, n} * 33'd83887;
        shifted = prod >> 23;
      end
      3: begin
        prod    = {17'd0, n} * 33'd67109;
        shifted = prod >> 26;
      end
      4: begin
        prod    = {17'd0, n} * 33'd107375;
        shifted = prod >> 30;
      end
      default: begin
        shifted = '0;
      end
    endcase
    return shifted[NumW-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fdse_divide.sv
// ----------------------------------------------------------------------------
// fdse_divide
// Input register and decimal quotient stage: splits the number into its
// powers-of-ten quotients, one constant multiply per quotient after the first.
// ----------------------------------------------------------------------------
`default_nettype none

module fdse_divide #(
  parameter int unsigned NumPositions = fdse_pkg::NumPositionsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire fdse_pkg::fdse_req_t   in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output fdse_pkg::fdse_ctrl_t       out_ctrl_o,
  output logic [fdse_pkg::NumW-1:0]  out_quot_o [NumPositions+1]
);
  import fdse_pkg::*;

  logic            req_valid_q;
  fdse_req_t       req_q;
  logic            quot_valid_q;
  fdse_ctrl_t      ctrl_q;
  logic [NumW-1:0] quot_q [NumPositions+1];
  logic [NumW-1:0] quot_d [NumPositions+1];
  logic            req_adv;
  logic            quot_adv;

  assign quot_adv   = !quot_valid_q || out_ready_i;
  assign req_adv    = !req_valid_q || quot_adv;
  assign in_ready_o = req_adv;

  always_comb begin
    for (int unsigned k = 0; k <= NumPositions; k++) begin
      quot_d[k] = div_pow10(req_q.number, k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q  <= 1'b0;
      quot_valid_q <= 1'b0;
    end else begin
      if (req_adv) begin
        req_valid_q <= in_valid_i;
      end
      if (quot_adv) begin
        quot_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_adv && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (quot_adv && req_valid_q) begin
      ctrl_q.cmd      <= req_q.cmd;
      ctrl_q.places   <= req_q.places;
      ctrl_q.position <= req_q.position;
      ctrl_q.code     <= req_q.code;
      quot_q          <= quot_d;
    end
  end

  assign out_valid_o = quot_valid_q;
  assign out_ctrl_o  = ctrl_q;
  assign out_quot_o  = quot_q;

endmodule

`default_nettype wire

### hw/rtl/four_digit_segment_display_encoder_core.sv
// ----------------------------------------------------------------------------
// four_digit_segment_display_encoder_core
// Segment image store for a multi-digit display, updated by show-number and
// set-digit requests.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while results are taken at the output.
// Its result is offered once it has passed an input register, a register of
// decimal quotients (one constant multiply per digit) and the segment store
// itself, which also serves as the result register. The store holds while a
// result waits, and input is still taken until the two upper stages are full.
// Each result is the full image of positions 0 to 3 after the request; fields
// of positions that do not exist read zero. The store clears to zero at reset,
// with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module four_digit_segment_display_encoder_core #(
  parameter int unsigned NumPositions = fdse_pkg::NumPositionsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] number, [23:16] decimal_places, [25:24] position, [33:26] char_code
  input  wire logic [fdse_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] cmd
  input  wire logic [0:0]                     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [10:0] segments_pos0, [21:11] segments_pos1, [32:22] segments_pos2,
  // [43:33] segments_pos3
  output logic [fdse_pkg::OutDataW-1:0]       m_axis_tdata
);
  import fdse_pkg::*;

  fdse_req_t                  in_req;
  logic                       quot_valid;
  logic                       quot_ready;
  fdse_ctrl_t                 ctrl;
  logic [NumW-1:0]            quot [NumPositions+1];
  logic [NumW-1:0]            tens [NumPositions];
  logic [NumW-1:0]            diff [NumPositions];
  logic [3:0]                 digit [NumPositions];
  logic [SegW-1:0]            store_q [NumPositions];
  logic [SegW-1:0]            store_d [NumPositions];
  logic [NumPositions*SegW-1:0] store_flat;
  logic [NumPositions-1:0]    points;
  logic                       tx_any;
  glyph_t                     glyph;
  logic                       res_valid_q;
  logic                       res_valid_d;
  logic                       wr;

  assign in_req.cmd      = cmd_e'(s_axis_tuser[0]);
  assign in_req.number   = s_axis_tdata[15:0];
  assign in_req.places   = s_axis_tdata[23:16];
  assign in_req.position = s_axis_tdata[25:24];
  assign in_req.code     = s_axis_tdata[33:26];

  fdse_divide #(
    .NumPositions(NumPositions)
  ) u_divide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (in_req),
    .out_valid_o(quot_valid),
    .out_ready_i(quot_ready),
    .out_ctrl_o (ctrl),
    .out_quot_o (quot)
  );

  assign quot_ready = !res_valid_q || m_axis_tready;
  assign wr         = quot_valid && quot_ready;
  assign glyph      = glyph_of(ctrl.code);

  always_comb begin
    for (int unsigned k = 0; k < NumPositions; k++) begin
      tens[k]  = (quot[k+1] << 3) + (quot[k+1] << 1);
      diff[k]  = quot[k] - tens[k];
      digit[k] = diff[k][3:0];
    end
  end

  always_comb begin
    for (int unsigned p = 0; p < NumPositions; p++) begin
      store_d[p] = store_q[p];
      if (ctrl.cmd == CmdShowNumber) begin
        if (p == NumPositions - 1 || quot[NumPositions-1-p] != '0) begin
          store_d[p] = {store_q[p][SegW-1], digit_shape(digit[NumPositions-1-p])};
        end else begin
          store_d[p] = {store_q[p][SegW-1], ShapeBlank};
        end
        if (32'(ctrl.places) < NumPositions) begin
          store_d[p][SegW-1] = (p == NumPositions - 1 - 32'(ctrl.places));
        end
      end else if (glyph.known && 32'(ctrl.position) == p) begin
        store_d[p] = {store_q[p][SegW-1], glyph.shape};
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (wr) begin
      res_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      for (int unsigned p = 0; p < NumPositions; p++) begin
        store_q[p] <= '0;
      end
    end else begin
      res_valid_q <= res_valid_d;
      if (wr) begin
        store_q <= store_d;
      end
    end
  end

  always_comb begin
    tx_any = 1'b0;
    for (int unsigned p = 0; p < NumPositions; p++) begin
      store_flat[p*SegW +: SegW] = store_q[p];
      points[p]                  = store_q[p][SegW-1];
      tx_any                     = tx_any | (|store_q[p][9:8]);
    end
  end

  assign m_axis_tvalid = res_valid_q;

  for (genvar i = 0; i < OutFields; i++) begin : g_out
    if (i < NumPositions) begin : g_pos
      assign m_axis_tdata[i*SegW +: SegW] = store_q[i];
    end else begin : g_none
      assign m_axis_tdata[i*SegW +: SegW] = '0;
    end
  end
  assign m_axis_tdata[OutDataW-1:OutFields*SegW] = '0;

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result stage");

  a_store_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr |=> $stable(store_flat))
    else $error("segment store changed without a write");

  a_tx_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> !tx_any)
    else $error("T or X segment set after an update");

  a_single_point : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && ctrl.cmd == CmdShowNumber && 32'(ctrl.places) < NumPositions
    |=> $countones(points) == 1)
    else $error("decimal point not unique after show-number");

  a_rightmost_lit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && ctrl.cmd == CmdShowNumber |=> store_q[NumPositions-1][5:0] != '0)
    else $error("rightmost position blank after show-number");

endmodule

`default_nettype wire

### tb/four_digit_segment_display_encoder_core_test.sv
// ----------------------------------------------------------------------------
// four_digit_segment_display_encoder_core_test
// Self-checking bench for the segment display encoder: show-number and
// set-digit requests go in over the input stream, and a shadow copy of the
// four segment images predicts every result, which is compared field by
// field as it leaves the output stream. Directed corner cases come first,
// then random traffic with random gaps on both sides, a stretch without
// gaps and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module four_digit_segment_display_encoder_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  import fdse_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned MaxReported   = 10;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  wire                 s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic [0:0]          s_axis_tuser   = '0;
  wire                 m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  wire [OutDataW-1:0]  m_axis_tdata;

  logic                tx_idle_en     = 1'b1;
  logic                rx_idle_en     = 1'b1;
  logic                holdoff_start  = 1'b0;
  int unsigned         holdoff_left;

  logic [SegW-1:0]     shadow_images [NumPositionsDefault];
  logic [OutDataW-1:0] expected_images [$];
  int unsigned         mismatch_count;
  int unsigned         results_checked;
  int unsigned         shows_taken;
  int unsigned         sets_taken;

  four_digit_segment_display_encoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic decode_char(input logic [7:0] code, output logic [ShapeW-1:0] shape);
    logic [7:0] digit;
    digit = code;
    if (code >= CharZero && code <= CharNine) digit = code - CharZero;
    shape = '0;
    if (digit <= DigitMax) begin
      case (digit[3:0])
        4'd0:    shape = 10'b00_0011_1111;
        4'd1:    shape = 10'b00_0000_0110;
        4'd2:    shape = 10'b00_1101_1011;
        4'd3:    shape = 10'b00_1100_1111;
        4'd4:    shape = 10'b00_1110_0110;
        4'd5:    shape = 10'b00_1110_1101;
        4'd6:    shape = 10'b00_1111_1101;
        4'd7:    shape = 10'b00_0000_0111;
        4'd8:    shape = 10'b00_1111_1111;
        default: shape = 10'b00_1110_1111;
      endcase
      return 1'b1;
    end
    if (code == CharSpace) return 1'b1;
    if (code == CharDegree) begin
      shape = 10'b00_1110_0011;
      return 1'b1;
    end
    if (code == CharUpperC) begin
      shape = 10'b00_0011_1001;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void write_char(input int pos, input logic [7:0] code);
    logic [ShapeW-1:0] shape;
    if (decode_char(code, shape)) shadow_images[pos] = {shadow_images[pos][SegW-1], shape};
  endfunction

  function automatic logic [OutDataW-1:0] update_images(input fdse_req_t req);
    logic [NumW-1:0]     rest;
    logic [OutDataW-1:0] image;
    rest  = req.number;
    image = '0;
    if (req.cmd == CmdShowNumber) begin
      for (int pos = NumPositionsDefault - 1; pos >= 0; pos--) begin
        if (rest == 0) begin
          write_char(pos, (pos == NumPositionsDefault - 1) ? 8'd0 : CharSpace);
        end else begin
          write_char(pos, 8'(rest % 10));
          rest = rest / 10;
        end
      end
      if (req.places < NumPositionsDefault) begin
        for (int pos = 0; pos < NumPositionsDefault; pos++) shadow_images[pos][SegW-1] = 1'b0;
        shadow_images[NumPositionsDefault - 1 - int'(req.places)][SegW-1] = 1'b1;
      end
    end else begin
      write_char(int'(req.position), req.code);
    end
    for (int pos = 0; pos < OutFields; pos++) image[pos*SegW +: SegW] = shadow_images[pos];
    return image;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      holdoff_left  <= 0;
    end else if (holdoff_start) begin
      m_axis_tready <= 1'b0;
      holdoff_left  <= HoldoffCycles;
    end else if (holdoff_left != 0) begin
      m_axis_tready <= 1'b0;
      holdoff_left  <= holdoff_left - 1;
    end else begin
      m_axis_tready <= !rx_idle_en || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    logic [OutDataW-1:0] want;
    fdse_req_t           req;
    if (!rst_ni) begin
      for (int pos = 0; pos < NumPositionsDefault; pos++) shadow_images[pos] = '0;
      expected_images.delete();
      mismatch_count  = 0;
      results_checked = 0;
      shows_taken     = 0;
      sets_taken      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_images.size() == 0) begin
          if (mismatch_count < MaxReported)
            $display("unexpected result: actual %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_images.pop_front();
          results_checked++;
          for (int f = 0; f < OutFields; f++) begin
            if (want[f*SegW +: SegW] !== m_axis_tdata[f*SegW +: SegW]) begin
              if (mismatch_count < MaxReported)
                $display("result %0d segments_pos%0d: expected %h, actual %h",
                         results_checked, f, want[f*SegW +: SegW],
                         m_axis_tdata[f*SegW +: SegW]);
              mismatch_count++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.cmd      = cmd_e'(s_axis_tuser[0]);
        req.number   = s_axis_tdata[15:0];
        req.places   = s_axis_tdata[23:16];
        req.position = s_axis_tdata[25:24];
        req.code     = s_axis_tdata[33:26];
        if (req.cmd == CmdShowNumber) shows_taken++;
        else sets_taken++;
        expected_images.push_back(update_images(req));
      end
    end
  end

  task automatic send_request(input cmd_e cmd, input logic [NumW-1:0] number,
                              input logic [7:0] places, input logic [1:0] position,
                              input logic [7:0] code);
    while (tx_idle_en && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= 1'(cmd);
    s_axis_tdata  <= {6'd0, code, position, places, number};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [NumW-1:0] random_number();
    case ($urandom_range(3))
      0:       return NumW'($urandom_range(9));
      1:       return NumW'($urandom_range(999));
      2:       return NumW'($urandom_range(9999));
      default: return NumW'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_places();
    if ($urandom_range(99) < 80) return 8'($urandom_range(NumPositionsDefault));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] random_code();
    if ($urandom_range(99) < 30) return 8'($urandom);
    case ($urandom_range(4))
      0:       return 8'($urandom_range(DigitMax));
      1:       return 8'($urandom_range(CharNine, CharZero));
      2:       return CharSpace;
      3:       return CharUpperC;
      default: return CharDegree;
    endcase
  endfunction

  task automatic test_directed_cases();
    send_request(CmdShowNumber, 16'd0,     8'd255, 2'($urandom), 8'($urandom));
    send_request(CmdShowNumber, 16'd65535, 8'd0,   2'($urandom), 8'($urandom));
    send_request(CmdShowNumber, 16'd9876,  8'd1,   2'($urandom), 8'($urandom));
    send_request(CmdShowNumber, 16'd5432,  8'd2,   2'($urandom), 8'($urandom));
    send_request(CmdShowNumber, 16'd10,    8'd3,   2'($urandom), 8'($urandom));
    send_request(CmdShowNumber, 16'd7,     8'd4,   2'($urandom), 8'($urandom));
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd0, 8'd0);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd1, DigitMax);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd2, CharZero);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd3, CharNine);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd0, CharSpace);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd1, CharUpperC);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd2, CharDegree);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd3, 8'd10);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd0, CharZero - 8'd1);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd1, CharNine + 8'd1);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd2, 8'd255);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd3, CharDegree - 8'd1);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd0, CharDegree + 8'd1);
    send_request(CmdSetDigit, 16'($urandom), 8'($urandom), 2'd1, CharUpperC + 8'd1);
    send_request(CmdShowNumber, 16'd1000,  8'd255, 2'($urandom), 8'($urandom));
    send_request(CmdShowNumber, 16'd99,    8'd128, 2'($urandom), 8'($urandom));
    send_request(CmdShowNumber, 16'd1,     8'd0,   2'($urandom), 8'($urandom));
  endtask

  task automatic test_random_mix(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(1) == 0)
        send_request(CmdShowNumber, random_number(), random_places(),
                     2'($urandom), 8'($urandom));
      else
        send_request(CmdSetDigit, 16'($urandom), 8'($urandom),
                     2'($urandom), random_code());
    end
  endtask

  task automatic test_steady_stream(input int unsigned count);
    tx_idle_en  = 1'b0;
    rx_idle_en <= 1'b0;
    test_random_mix(count);
    tx_idle_en  = 1'b1;
    rx_idle_en <= 1'b1;
  endtask

  task automatic test_output_holdoff();
    tx_idle_en     = 1'b0;
    s_axis_tvalid <= 1'b0;
    holdoff_start <= 1'b1;
    @(posedge clk_i);
    holdoff_start <= 1'b0;
    test_random_mix(40);
    tx_idle_en = 1'b1;
  endtask

  initial begin : main
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_mix(500);
    test_steady_stream(300);
    test_output_holdoff();
    test_random_mix(340);
    s_axis_tvalid <= 1'b0;
    while (expected_images.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("covered %0d show-number and %0d set-digit requests, %0d results checked,",
             shows_taken, sets_taken, results_checked);
    $display("with random gaps, a gap-free stretch and a %0d-cycle output hold-off",
             HoldoffCycles);
    if (mismatch_count == 0 && expected_images.size() == 0) begin
      $display("four_digit_segment_display_encoder_core_test: done, clean");
    end else begin
      $display("four_digit_segment_display_encoder_core_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("cycle limit reached with %0d results outstanding", expected_images.size());
    $display("four_digit_segment_display_encoder_core_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
